[rtl/core/feq_pkg.sv]
// ----------------------------------------------------------------------------
// Flame event qualifier package
// Item types, result kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package feq_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic [1:0] {
    KindDetected = 2'd0,
    KindClear    = 2'd1,
    KindData     = 2'd2
  } feq_kind_e;

  localparam logic [1:0] SevDetected = 2'd3;
  localparam logic [1:0] SevNone     = 2'd0;

  localparam logic [CfgIdxW-1:0] RegBaseline   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDebounce   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLimit      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegResend     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDataPeriod = 3'd5;

  localparam logic [11:0] BaselineRst   = 12'd2048;
  localparam logic [11:0] ThresholdRst  = 12'd300;
  localparam logic [15:0] DebounceRst   = 16'd50;
  localparam logic [15:0] LimitRst      = 16'd500;
  localparam logic [15:0] ResendRst     = 16'd5000;
  localparam logic [15:0] DataPeriodRst = 16'd1000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] sample;
    logic        link_up;
  } feq_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  severity;
    logic [11:0] reading;
    logic [11:0] deviation;
    logic        last;
  } feq_out_t;

endpackage

[rtl/core/flame_event_qualifier_core.sv]
// ----------------------------------------------------------------------------
// Flame event qualifier core
// Baseline offset detection with debounce, rate-limited state events,
// periodic resend of detection, link-up re-report and periodic data reports.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register until the result buffer
//   is free; its results are then registered there and offered in order.
// Throughput: one item per cycle if it causes at most one result and the single
//   result port is not stalled; more results (up to 4) hold back the next item.
// Reset: all state timers and flags clear, registers take their default values.
module flame_event_qualifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [feq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [feq_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  feq_pkg::feq_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output feq_pkg::feq_out_t             out_data_o
);
  import feq_pkg::*;

  localparam logic [11:0] SampleMask = 12'((1 << SampleBits) - 1);

  function automatic logic due(input logic [31:0] now, input logic [31:0] since,
                               input logic [15:0] per);
    logic [31:0] diff;
    diff = now - since;
    return diff >= {16'd0, per};
  endfunction

  // configuration
  logic [11:0] baseline_q, threshold_q;
  logic [15:0] debounce_q, limit_q, resend_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q  <= BaselineRst;
      threshold_q <= ThresholdRst;
      debounce_q  <= DebounceRst;
      limit_q     <= LimitRst;
      resend_q    <= ResendRst;
      period_q    <= DataPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBaseline:   baseline_q  <= cfg_data_i[11:0];
        RegThreshold:  threshold_q <= cfg_data_i[11:0];
        RegDebounce:   debounce_q  <= cfg_data_i;
        RegLimit:      limit_q     <= cfg_data_i;
        RegResend:     resend_q    <= cfg_data_i;
        RegDataPeriod: period_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic    a_valid_q;
  feq_in_t a_q;
  logic    buf_free, a_adv;

  assign a_adv      = a_valid_q && buf_free;
  assign in_ready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= in_data_i;
    end
  end

  // qualifier state
  logic        started_q, raw_prev_q, confirmed_q, link_prev_q, held_valid_q, held_value_q;
  logic [31:0] rct_q, event_time_q, detect_time_q, data_time_q;
  logic        started_d, raw_prev_d, confirmed_d, link_prev_d, held_valid_d, held_value_d;
  logic [31:0] rct_d, event_time_d, detect_time_d, data_time_d;

  logic [11:0] smp, base, dev;
  logic        raw;
  logic [1:0]  kind_d [4];
  logic [2:0]  res_n;

  always_comb begin
    smp = a_q.sample & SampleMask;
    base = baseline_q & SampleMask;
    dev = (smp >= base) ? (smp - base) : (base - smp);
    raw = dev > threshold_q;

    started_d     = started_q;
    raw_prev_d    = raw_prev_q;
    confirmed_d   = confirmed_q;
    link_prev_d   = link_prev_q;
    held_valid_d  = held_valid_q;
    held_value_d  = held_value_q;
    rct_d         = rct_q;
    event_time_d  = event_time_q;
    detect_time_d = detect_time_q;
    data_time_d   = data_time_q;
    res_n         = 3'd0;
    for (int i = 0; i < 4; i++) begin
      kind_d[i] = KindData;
    end

    if (!started_q) begin
      started_d     = 1'b1;
      raw_prev_d    = raw;
      confirmed_d   = raw;
      data_time_d   = a_q.now_ms;
      detect_time_d = a_q.now_ms;
    end else begin
      // link rising edge: repeat accepted state
      if (a_q.link_up && !link_prev_q) begin
        kind_d[res_n[1:0]] = confirmed_q ? KindDetected : KindClear;
        res_n = res_n + 3'd1;
        if (confirmed_q) begin
          detect_time_d = a_q.now_ms;
        end
      end
      link_prev_d = a_q.link_up;

      // debounce, state event or resend
      if (raw != raw_prev_q) begin
        raw_prev_d = raw;
        rct_d      = a_q.now_ms;
      end else if (due(a_q.now_ms, rct_q, debounce_q)) begin
        if (raw != confirmed_q) begin
          confirmed_d = raw;
          if (due(a_q.now_ms, event_time_q, limit_q)) begin
            event_time_d = a_q.now_ms;
            kind_d[res_n[1:0]] = raw ? KindDetected : KindClear;
            res_n = res_n + 3'd1;
            if (raw) begin
              detect_time_d = a_q.now_ms;
            end
          end else begin
            held_valid_d = 1'b1;
            held_value_d = raw;
          end
        end else if (confirmed_q) begin
          if (due(a_q.now_ms, detect_time_d, resend_q)) begin
            detect_time_d = a_q.now_ms;
            kind_d[res_n[1:0]] = KindDetected;
            res_n = res_n + 3'd1;
          end
        end
      end

      // flush of a held event
      if (held_valid_d && due(a_q.now_ms, event_time_d, limit_q)) begin
        held_valid_d = 1'b0;
        event_time_d = a_q.now_ms;
        kind_d[res_n[1:0]] = held_value_d ? KindDetected : KindClear;
        res_n = res_n + 3'd1;
        if (held_value_d) begin
          detect_time_d = a_q.now_ms;
        end
      end

      // periodic data report
      if (due(a_q.now_ms, data_time_q, period_q)) begin
        data_time_d = a_q.now_ms;
        kind_d[res_n[1:0]] = KindData;
        res_n = res_n + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      raw_prev_q    <= 1'b0;
      confirmed_q   <= 1'b0;
      link_prev_q   <= 1'b0;
      held_valid_q  <= 1'b0;
      held_value_q  <= 1'b0;
      rct_q         <= '0;
      event_time_q  <= '0;
      detect_time_q <= '0;
      data_time_q   <= '0;
    end else if (a_adv) begin
      started_q     <= started_d;
      raw_prev_q    <= raw_prev_d;
      confirmed_q   <= confirmed_d;
      link_prev_q   <= link_prev_d;
      held_valid_q  <= held_valid_d;
      held_value_q  <= held_value_d;
      rct_q         <= rct_d;
      event_time_q  <= event_time_d;
      detect_time_q <= detect_time_d;
      data_time_q   <= data_time_d;
    end
  end

  // result buffer: one item's results, drained one per cycle while out_ready_i is high
  logic [1:0]  kind_q [4];
  logic [11:0] reading_q, deviation_q;
  logic [2:0]  n_q;
  logic [1:0]  idx_q;
  logic        out_last, out_fire;
  feq_kind_e   out_kind;

  assign out_valid_o = (n_q != 3'd0);
  assign out_last    = ({1'b0, idx_q} == (n_q - 3'd1));
  assign out_fire    = out_valid_o && out_ready_i;
  assign buf_free    = !out_valid_o || (out_fire && out_last);
  assign out_kind    = feq_kind_e'(kind_q[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= 3'd0;
      idx_q <= 2'd0;
    end else if (a_adv) begin
      n_q   <= res_n;
      idx_q <= 2'd0;
    end else if (out_fire) begin
      if (out_last) begin
        n_q   <= 3'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      kind_q      <= kind_d;
      reading_q   <= smp;
      deviation_q <= dev;
    end
  end

  always_comb begin
    out_data_o.kind      = out_kind;
    out_data_o.severity  = (out_kind == KindDetected) ? SevDetected : SevNone;
    out_data_o.reading   = reading_q;
    out_data_o.deviation = deviation_q;
    out_data_o.last      = out_last;
  end

endmodule

[rtl/core/feq_checker.sv]
// ----------------------------------------------------------------------------
// Flame event qualifier port checker
// Watches the result port of the core; attached by bind.
// ----------------------------------------------------------------------------
module feq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input feq_pkg::feq_out_t    out_data_o
);
  import feq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_severity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind != 2'd3) &&
      ((out_data_o.kind == KindDetected) == (out_data_o.severity == SevDetected)) &&
      (out_data_o.severity == SevDetected || out_data_o.severity == SevNone))
    else $error("severity does not match kind");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("item results broken off before last");

  a_group_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_data_o.reading == $past(out_data_o.reading) &&
      out_data_o.deviation == $past(out_data_o.deviation))
    else $error("reading differs within one item");

endmodule

bind flame_event_qualifier_core feq_checker u_feq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
